// ===== sv/ray_sphere_intersect_macros.svh =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect_macros
// Assertion macros for the ray/sphere intersect block. They expand to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH
`ifndef SYNTH
`define RSI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RSI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSI_ASSERT_IMP(label, ante, cons, msg)
`define RSI_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Types, widths and pipeline depths shared by the ray/sphere intersect block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  localparam int QUAD_LAT   = 5;
  localparam int SQRT_STEPS = 50;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int TOTAL_LAT  = QUAD_LAT + SQRT_STEPS + 1 + DIV_LAT + 3 + DIV_LAT + 1;

  localparam int A_W    = 48;
  localparam int H_W    = 50;
  localparam int DISC_W = 100;
  localparam int S_W    = 50;
  localparam int NUM_W  = 52;
  localparam int DEN_W  = 48;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd3;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] t_min;
    logic signed [31:0] t_max;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_distance;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               front_face;
  } result_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [30:0] sphere_radius;
  } cfg_t;

  typedef struct packed {
    ray_t                    ray;
    logic        [A_W-1:0]   a;
    logic signed [H_W-1:0]   h;
    logic        [DISC_W-1:0] disc;
    logic                    ok;
  } quad_t;

endpackage

`default_nettype wire

// ===== sv/rsi_quad.sv =====
// ----------------------------------------------------------------------------
// rsi_quad
// Front end: oc = O - C, the dot products a, h, c and the discriminant
// h*h - a*c, in five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_quad (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  rsi_pkg::ray_t  in_ray,
  input  rsi_pkg::cfg_t  cfg,
  output logic           out_valid,
  output rsi_pkg::quad_t out_q
);

  localparam int L = rsi_pkg::QUAD_LAT;

  logic [L-1:0]  vld_r;
  rsi_pkg::ray_t ray_r [L];

  logic signed [31:0] cen [3];
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];

  // stage 1
  logic signed [32:0] oc_r [3];
  // stage 2
  logic signed [63:0] dd_r [3];
  logic signed [64:0] od_r [3];
  logic        [63:0] oo_r [3];
  logic        [61:0] rr_r;
  logic        [31:0] ocm [3];
  // stage 3
  logic        [rsi_pkg::A_W-1:0] a_nxt, a3_r, a4_r;
  logic signed [rsi_pkg::H_W-1:0] h_nxt, h3_r, h4_r;
  logic signed [50:0]             c_nxt, c3_r;
  logic                           anz3_r, anz4_r;
  // stage 4
  logic [48:0] hm;
  logic [49:0] cm;
  logic [49:0] p_hl_hl_r, p_hl_hh_r, p_hh_hh_r;
  logic [49:0] p_al_cl_r, p_al_ch_r, p_ah_cl_r, p_ah_ch_r;
  logic        cneg_r;
  // stage 5
  logic [rsi_pkg::DISC_W-1:0] h2, ac, disc_nxt;
  rsi_pkg::quad_t             q_r;

  always_comb begin
    cen[0] = cfg.center_x;
    cen[1] = cfg.center_y;
    cen[2] = cfg.center_z;
    org[0] = in_ray.origin_x;
    org[1] = in_ray.origin_y;
    org[2] = in_ray.origin_z;
    dir[0] = ray_r[0].dir_x;
    dir[1] = ray_r[0].dir_y;
    dir[2] = ray_r[0].dir_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[L-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ray_r[0] <= in_ray;
    for (int k = 1; k < L; k++) begin
      ray_r[k] <= ray_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      oc_r[i] <= 33'(org[i]) - 33'(cen[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ocm[i] = oc_r[i][32] ? 32'(-oc_r[i]) : oc_r[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dd_r[i] <= 64'(dir[i]) * 64'(dir[i]);
      od_r[i] <= 65'(oc_r[i]) * 65'(dir[i]);
      oo_r[i] <= 64'(ocm[i]) * 64'(ocm[i]);
    end
    rr_r <= 62'(cfg.sphere_radius) * 62'(cfg.sphere_radius);
  end

  // terms floored to Q.16 before the sums
  always_comb begin
    a_nxt = 48'(dd_r[0][62:16]) + 48'(dd_r[1][62:16]) + 48'(dd_r[2][62:16]);
    h_nxt = 50'($signed(od_r[0][64:16])) + 50'($signed(od_r[1][64:16]))
          + 50'($signed(od_r[2][64:16]));
    c_nxt = 51'(oo_r[0][63:16]) + 51'(oo_r[1][63:16]) + 51'(oo_r[2][63:16])
          - 51'(rr_r[61:16]);
  end

  always_ff @(posedge clk) begin
    a3_r   <= a_nxt;
    h3_r   <= h_nxt;
    c3_r   <= c_nxt;
    anz3_r <= (a_nxt != '0);
  end

  always_comb begin
    hm = h3_r[49] ? 49'(-h3_r) : h3_r[48:0];
    cm = c3_r[50] ? 50'(-c3_r) : c3_r[49:0];
  end

  always_ff @(posedge clk) begin
    p_hl_hl_r <= 50'(hm[24:0]) * 50'(hm[24:0]);
    p_hl_hh_r <= 50'(hm[24:0]) * 50'(hm[48:25]);
    p_hh_hh_r <= 50'(hm[48:25]) * 50'(hm[48:25]);
    p_al_cl_r <= 50'(a3_r[24:0]) * 50'(cm[24:0]);
    p_al_ch_r <= 50'(a3_r[24:0]) * 50'(cm[49:25]);
    p_ah_cl_r <= 50'(a3_r[47:25]) * 50'(cm[24:0]);
    p_ah_ch_r <= 50'(a3_r[47:25]) * 50'(cm[49:25]);
    cneg_r    <= c3_r[50];
    a4_r      <= a3_r;
    h4_r      <= h3_r;
    anz4_r    <= anz3_r;
  end

  always_comb begin
    h2 = (100'(p_hh_hh_r) << 50) + (100'(p_hl_hh_r) << 26) + 100'(p_hl_hl_r);
    ac = (100'(p_ah_ch_r) << 50) + ((100'(p_al_ch_r) + 100'(p_ah_cl_r)) << 25)
       + 100'(p_al_cl_r);
    disc_nxt = cneg_r ? h2 + ac : h2 - ac;
  end

  always_ff @(posedge clk) begin
    q_r.ray  <= ray_r[L-2];
    q_r.a    <= a4_r;
    q_r.h    <= h4_r;
    q_r.disc <= disc_nxt;
    q_r.ok   <= anz4_r && (cfg.sphere_radius != '0) && !disc_nxt[rsi_pkg::DISC_W-1];
  end

  assign out_valid = vld_r[L-1];
  assign out_q     = q_r;

endmodule

`default_nettype wire

// ===== sv/rsi_sqrt.sv =====
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined floor square root, one root bit per stage, restoring form.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_sqrt (
  input  logic                        clk,
  input  logic [rsi_pkg::DISC_W-1:0]  rad,
  output logic [rsi_pkg::S_W-1:0]     root
);

  localparam int N  = rsi_pkg::SQRT_STEPS;
  localparam int RW = rsi_pkg::S_W + 2;
  localparam int XW = rsi_pkg::DISC_W;

  logic [RW-1:0]             rem_r  [N];
  logic [rsi_pkg::S_W-1:0]   root_r [N];
  logic [XW-1:0]             rad_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RW-1:0]           rem_in;
    logic [rsi_pkg::S_W-1:0] root_in;
    logic [XW-1:0]           rad_in;
    logic [RW+1:0]           acc, trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    assign acc   = {rem_in, rad_in[XW-1:XW-2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (acc >= trial) begin
        rem_r[k]  <= RW'(acc - trial);
        root_r[k] <= {root_in[rsi_pkg::S_W-2:0], 1'b1};
      end else begin
        rem_r[k]  <= acc[RW-1:0];
        root_r[k] <= {root_in[rsi_pkg::S_W-2:0], 1'b0};
      end
      rad_r[k] <= {rad_in[XW-3:0], 2'b00};
    end
  end

  assign root = root_r[N-1];

endmodule

`default_nettype wire

// ===== sv/rsi_div.sv =====
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined Q16.16 divide: (num * 2^16) / den truncated toward zero and
// saturated to 32 bits. Entry stage, one quotient bit per stage, exit stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_div (
  input  logic                              clk,
  input  logic signed [rsi_pkg::NUM_W-1:0]  num,
  input  logic        [rsi_pkg::DEN_W-1:0]  den,
  output logic signed [31:0]                quo
);

  localparam int N  = rsi_pkg::DIV_STEPS;
  localparam int MW = rsi_pkg::NUM_W - 1;
  localparam int DW = rsi_pkg::DEN_W;

  logic [MW-1:0] mag;

  logic [DW-1:0] rem_r [N+1];
  logic [DW-1:0] den_r [N+1];
  logic [15:0]   low_r [N+1];
  logic [31:0]   q_r   [N+1];
  logic          neg_r [N+1];
  logic          ovf_r [N+1];
  logic signed [31:0] quo_r;

  assign mag = num[rsi_pkg::NUM_W-1] ? MW'(-num) : num[MW-1:0];

  always_ff @(posedge clk) begin
    rem_r[0] <= DW'(mag >> 16);
    den_r[0] <= den;
    low_r[0] <= mag[15:0];
    q_r[0]   <= '0;
    neg_r[0] <= num[rsi_pkg::NUM_W-1];
    ovf_r[0] <= 64'(mag) >= {den, 16'h0000};
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [DW:0] acc;
    assign acc = {rem_r[k-1], low_r[k-1][15]};

    always_ff @(posedge clk) begin
      if (acc >= {1'b0, den_r[k-1]}) begin
        rem_r[k] <= DW'(acc - {1'b0, den_r[k-1]});
        q_r[k]   <= {q_r[k-1][30:0], 1'b1};
      end else begin
        rem_r[k] <= acc[DW-1:0];
        q_r[k]   <= {q_r[k-1][30:0], 1'b0};
      end
      den_r[k] <= den_r[k-1];
      low_r[k] <= {low_r[k-1][14:0], 1'b0};
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (neg_r[N]) begin
      quo_r <= (ovf_r[N] || q_r[N] > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(q_r[N]);
    end else begin
      quo_r <= (ovf_r[N] || q_r[N][31]) ? 32'sh7fff_ffff : $signed(q_r[N]);
    end
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

// ===== sv/ray_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray against a configured sphere, half-b quadratic in Q16.16 fixed point.
//
//   channel  ports                               beat marked by
//   input    start, busy, in_ray                 start && !busy
//   result   out_strobe, out_result              out_strobe (one cycle)
//   config   cfg_we, cfg_index, cfg_data         cfg_we
//
// One ray enters per cycle; busy stays low. Each result passes through 5
// quadratic stages, 50 square root stages, one numerator stage, 34 stages
// for the root divides, 3 select/point stages, 34 stages for the normal
// divides and one output register. Sync reset clears the valid bits and the
// sphere registers; the result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  rsi_pkg::ray_t                     in_ray,
  output logic                              out_strobe,
  output rsi_pkg::result_t                  out_result,
  input  logic                              cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int SQ = rsi_pkg::SQRT_STEPS;
  localparam int DL = rsi_pkg::DIV_LAT;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } shade_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647)       return 32'sh7fff_ffff;
    else if (v < -49'sd2147483648) return 32'sh8000_0000;
    else                           return 32'(v);
  endfunction

  rsi_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x      <= '0;
      cfg_r.center_y      <= '0;
      cfg_r.center_z      <= '0;
      cfg_r.sphere_radius <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsi_pkg::REG_CENTER_X: cfg_r.center_x      <= cfg_data;
        rsi_pkg::REG_CENTER_Y: cfg_r.center_y      <= cfg_data;
        rsi_pkg::REG_CENTER_Z: cfg_r.center_z      <= cfg_data;
        rsi_pkg::REG_RADIUS:   cfg_r.sphere_radius <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // quadratic terms
  logic           qv;
  rsi_pkg::quad_t qd;

  rsi_quad u_quad (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_ray    (in_ray),
    .cfg       (cfg_r),
    .out_valid (qv),
    .out_q     (qd)
  );

  // square root, with the item riding alongside
  logic [rsi_pkg::S_W-1:0] s;
  rsi_pkg::quad_t          qd_dly_r [SQ];
  logic [SQ-1:0]           qv_dly_r;

  rsi_sqrt u_sqrt (
    .clk  (clk),
    .rad  (qd.disc),
    .root (s)
  );

  always_ff @(posedge clk) begin
    qd_dly_r[0] <= qd;
    for (int k = 1; k < SQ; k++) begin
      qd_dly_r[k] <= qd_dly_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_dly_r <= '0;
    end else begin
      qv_dly_r <= {qv_dly_r[SQ-2:0], qv};
    end
  end

  // root numerators
  logic signed [rsi_pkg::NUM_W-1:0] nm_near_r, nm_far_r;
  logic        [rsi_pkg::A_W-1:0]   nm_a_r;
  rsi_pkg::ray_t                    nm_ray_r;
  logic                             nm_ok_r, nm_v_r;
  logic signed [rsi_pkg::NUM_W-1:0] h_ext, s_ext;

  assign h_ext = rsi_pkg::NUM_W'(qd_dly_r[SQ-1].h);
  assign s_ext = $signed({2'b00, s});

  always_ff @(posedge clk) begin
    nm_near_r <= -h_ext - s_ext;
    nm_far_r  <= -h_ext + s_ext;
    nm_a_r    <= qd_dly_r[SQ-1].a;
    nm_ray_r  <= qd_dly_r[SQ-1].ray;
    nm_ok_r   <= qd_dly_r[SQ-1].ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_v_r <= 1'b0;
    end else begin
      nm_v_r <= qv_dly_r[SQ-1];
    end
  end

  // root divides
  logic signed [31:0] t_near, t_far;
  rsi_pkg::ray_t      dv_ray_r [DL];
  logic               dv_ok_r  [DL];
  logic [DL-1:0]      dv_v_r;

  rsi_div u_div_near (
    .clk (clk),
    .num (nm_near_r),
    .den (nm_a_r),
    .quo (t_near)
  );

  rsi_div u_div_far (
    .clk (clk),
    .num (nm_far_r),
    .den (nm_a_r),
    .quo (t_far)
  );

  always_ff @(posedge clk) begin
    dv_ray_r[0] <= nm_ray_r;
    dv_ok_r[0]  <= nm_ok_r;
    for (int k = 1; k < DL; k++) begin
      dv_ray_r[k] <= dv_ray_r[k-1];
      dv_ok_r[k]  <= dv_ok_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r <= '0;
    end else begin
      dv_v_r <= {dv_v_r[DL-2:0], nm_v_r};
    end
  end

  // root select: near root first
  rsi_pkg::ray_t      dv_ray;
  logic               in_near, in_far;
  logic               sel_v_r, sel_hit_r;
  logic signed [31:0] sel_t_r;
  rsi_pkg::ray_t      sel_ray_r;

  assign dv_ray  = dv_ray_r[DL-1];
  assign in_near = (t_near > dv_ray.t_min) && (t_near < dv_ray.t_max);
  assign in_far  = (t_far > dv_ray.t_min) && (t_far < dv_ray.t_max);

  always_ff @(posedge clk) begin
    sel_hit_r <= dv_ok_r[DL-1] && (in_near || in_far);
    sel_t_r   <= in_near ? t_near : t_far;
    sel_ray_r <= dv_ray;
  end

  // t * D
  logic signed [31:0] sel_dir [3];
  logic signed [31:0] ml_org_r [3];
  logic signed [31:0] ml_dir_r [3];
  logic signed [63:0] ml_td_r [3];
  logic signed [31:0] ml_t_r;
  logic               ml_v_r, ml_hit_r;

  always_comb begin
    sel_dir[0] = sel_ray_r.dir_x;
    sel_dir[1] = sel_ray_r.dir_y;
    sel_dir[2] = sel_ray_r.dir_z;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ml_td_r[i]  <= 64'(sel_t_r) * 64'(sel_dir[i]);
      ml_dir_r[i] <= sel_dir[i];
    end
    ml_org_r[0] <= sel_ray_r.origin_x;
    ml_org_r[1] <= sel_ray_r.origin_y;
    ml_org_r[2] <= sel_ray_r.origin_z;
    ml_t_r      <= sel_t_r;
    ml_hit_r    <= sel_hit_r;
  end

  // hit point and P - C
  logic signed [31:0] cen [3];
  logic signed [48:0] wide [3];
  logic signed [31:0] wd_pt_r   [3];
  logic signed [49:0] wd_diff_r [3];
  logic signed [31:0] wd_dir_r  [3];
  logic signed [31:0] wd_t_r;
  logic               wd_v_r, wd_hit_r;

  always_comb begin
    cen[0] = cfg_r.center_x;
    cen[1] = cfg_r.center_y;
    cen[2] = cfg_r.center_z;
    for (int i = 0; i < 3; i++) begin
      wide[i] = 49'(ml_org_r[i]) + 49'(ml_td_r[i] >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      wd_pt_r[i]   <= sat32(wide[i]);
      wd_diff_r[i] <= 50'(wide[i]) - 50'(cen[i]);
      wd_dir_r[i]  <= ml_dir_r[i];
    end
    wd_t_r   <= ml_t_r;
    wd_hit_r <= ml_hit_r;
  end

  // normal divides
  logic signed [31:0] nrm [3];

  for (genvar i = 0; i < 3; i++) begin : g_norm
    rsi_div u_div_norm (
      .clk (clk),
      .num (rsi_pkg::NUM_W'(wd_diff_r[i])),
      .den (rsi_pkg::DEN_W'(cfg_r.sphere_radius)),
      .quo (nrm[i])
    );
  end

  // face test: sign of D . (P - C)
  logic signed [57:0] f1_lo_r [3];
  logic signed [57:0] f1_hi_r [3];
  logic signed [83:0] fdot;
  logic               fr_r [DL-1];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      f1_lo_r[i] <= 58'(wd_dir_r[i]) * 58'($signed({1'b0, wd_diff_r[i][24:0]}));
      f1_hi_r[i] <= 58'(wd_dir_r[i]) * 58'($signed(wd_diff_r[i][49:25]));
    end
  end

  always_comb begin
    fdot = '0;
    for (int i = 0; i < 3; i++) begin
      fdot = fdot + (84'(f1_hi_r[i]) <<< 25) + 84'(f1_lo_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    fr_r[0] <= fdot[83];
    for (int k = 1; k < DL - 1; k++) begin
      fr_r[k] <= fr_r[k-1];
    end
  end

  shade_t        sh_r [DL];
  logic [DL-1:0] sh_v_r;

  always_ff @(posedge clk) begin
    sh_r[0].hit <= wd_hit_r;
    sh_r[0].t   <= wd_t_r;
    sh_r[0].px  <= wd_pt_r[0];
    sh_r[0].py  <= wd_pt_r[1];
    sh_r[0].pz  <= wd_pt_r[2];
    for (int k = 1; k < DL; k++) begin
      sh_r[k] <= sh_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_v_r <= 1'b0;
      ml_v_r  <= 1'b0;
      wd_v_r  <= 1'b0;
      sh_v_r  <= '0;
    end else begin
      sel_v_r <= dv_v_r[DL-1];
      ml_v_r  <= sel_v_r;
      wd_v_r  <= ml_v_r;
      sh_v_r  <= {sh_v_r[DL-2:0], wd_v_r};
    end
  end

  // output register
  shade_t             sh;
  logic               front;
  logic signed [31:0] nrm_out [3];
  rsi_pkg::result_t   res_nxt;
  rsi_pkg::result_t   out_result_r;
  logic               out_strobe_r;

  assign sh    = sh_r[DL-1];
  assign front = fr_r[DL-2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (front) begin
        nrm_out[i] = nrm[i];
      end else begin
        nrm_out[i] = (nrm[i] == 32'sh8000_0000) ? 32'sh7fff_ffff : -nrm[i];
      end
    end
    res_nxt = '0;
    if (sh.hit) begin
      res_nxt.hit          = 1'b1;
      res_nxt.hit_distance = sh.t;
      res_nxt.point_x      = sh.px;
      res_nxt.point_y      = sh.py;
      res_nxt.point_z      = sh.pz;
      res_nxt.normal_x     = nrm_out[0];
      res_nxt.normal_y     = nrm_out[1];
      res_nxt.normal_z     = nrm_out[2];
      res_nxt.front_face   = front;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= sh_v_r[DL-1];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

`include "ray_sphere_intersect_macros.svh"

  `RSI_ASSERT_IMP(a_latency, start && !busy, ##(rsi_pkg::TOTAL_LAT) out_strobe, "beat lost in pipe")
  `RSI_ASSERT_IMP(a_miss_zero, out_strobe && !out_result.hit, out_result == '0, "miss not zeroed")
  `RSI_ASSERT_IMP(a_face_hit, out_strobe && out_result.front_face, out_result.hit, "face w/o hit")
  `RSI_ASSERT_NXT(a_hit_flow, sel_v_r && sel_hit_r, ml_v_r && ml_hit_r, "hit dropped at mult")

endmodule

`default_nettype wire

// ===== tb/tb_ray_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect
// Self-checking bench for the ray/sphere intersect block. Rays go in through
// the start/busy handshake in random bursts. A fixed-point model of the
// half-b quadratic predicts each result beat, and every strobed beat is
// compared against the oldest prediction, all fields for a hit. The sphere
// registers are rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ray_sphere_intersect;
  import rsi_pkg::*;

  localparam int DRAIN_CYCLES = TOTAL_LAT + 20;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  ray_t             in_ray;
  logic             out_strobe;
  result_t          out_result;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]      cfg_data;

  ray_t    ray_queue[$];
  result_t hit_queue[$];
  int      error_count;
  bit      hold_off;
  int      burst_left;
  int      gap_left;

  logic signed [63:0] sph_cx, sph_cy, sph_cz;
  logic        [63:0] sph_r;

  ray_sphere_intersect uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_ray     (in_ray),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] floor_q16(input logic signed [127:0] v);
    logic signed [127:0] q;
    q = v >>> 16;
    return q[63:0];
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // (num << 16) / den, truncated toward zero, saturated
  function automatic logic signed [63:0] div_fix(input logic signed [63:0] num,
                                                 input logic [63:0] den);
    logic [127:0] m;
    logic [127:0] q;
    m = (num < 0) ? 128'(-num) : 128'(num);
    q = (m << 16) / den;
    if (q > 128'd2147483648) q = 128'd2147483648;
    return clamp32((num < 0) ? -$signed(64'(q)) : $signed(64'(q)));
  endfunction

  function automatic result_t predict_hit(input ray_t ry);
    result_t res;
    logic signed [63:0] o[3], d[3], cen[3], oc, t, tmin, tmax, wd, df, nv;
    logic signed [63:0] a, h, c, s, pt[3], nrm[3];
    logic signed [127:0] disc, fdot, cand;
    logic front;
    res = '0;
    o[0] = ry.origin_x; o[1] = ry.origin_y; o[2] = ry.origin_z;
    d[0] = ry.dir_x;    d[1] = ry.dir_y;    d[2] = ry.dir_z;
    cen[0] = sph_cx; cen[1] = sph_cy; cen[2] = sph_cz;
    tmin = ry.t_min; tmax = ry.t_max;
    a = 0; h = 0; c = 0; s = 0; fdot = 0;
    if (sph_r == 0) return res;
    for (int i = 0; i < 3; i++) begin
      oc = o[i] - cen[i];
      a += floor_q16(128'(d[i]) * 128'(d[i]));
      h += floor_q16(128'(oc) * 128'(d[i]));
      c += floor_q16(128'(oc) * 128'(oc));
    end
    c -= $signed((sph_r * sph_r) >> 16);
    if (a <= 0) return res;
    disc = 128'(h) * 128'(h) - 128'(a) * 128'(c);
    if (disc < 0) return res;
    for (int b = 49; b >= 0; b--) begin
      cand = 128'(s | (64'sd1 <<< b));
      if (cand * cand <= disc) s = cand[63:0];
    end
    t = div_fix(-h - s, a);
    if (!(t > tmin && t < tmax)) begin
      t = div_fix(-h + s, a);
      if (!(t > tmin && t < tmax)) return res;
    end
    for (int i = 0; i < 3; i++) begin
      wd = o[i] + floor_q16(128'(t) * 128'(d[i]));
      df = wd - cen[i];
      pt[i] = clamp32(wd);
      nrm[i] = div_fix(df, sph_r);
      fdot += 128'(d[i]) * 128'(df);
    end
    front = fdot < 0;
    for (int i = 0; i < 3; i++) begin
      nv = front ? nrm[i] : clamp32(-nrm[i]);
      nrm[i] = nv;
    end
    res.hit = 1'b1;
    res.hit_distance = t[31:0];
    res.point_x = pt[0][31:0]; res.point_y = pt[1][31:0]; res.point_z = pt[2][31:0];
    res.normal_x = nrm[0][31:0]; res.normal_y = nrm[1][31:0];
    res.normal_z = nrm[2][31:0];
    res.front_face = front;
    return res;
  endfunction

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        hit_queue.push_back(predict_hit(in_ray));
      end
      if (start && busy) begin
        // hold the beat
      end else if (hold_off || ray_queue.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else begin
        in_ray <= ray_queue.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_strobe) begin
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %p", $time, out_result);
        error_count++;
      end else begin
        want = hit_queue.pop_front();
        if (want.hit !== out_result.hit ||
            (want.hit && (want.hit_distance !== out_result.hit_distance ||
             want.point_x !== out_result.point_x ||
             want.point_y !== out_result.point_y ||
             want.point_z !== out_result.point_z ||
             want.normal_x !== out_result.normal_x ||
             want.normal_y !== out_result.normal_y ||
             want.normal_z !== out_result.normal_z ||
             want.front_face !== out_result.front_face))) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, out_result);
          error_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CENTER_X: sph_cx = $signed(val);
      REG_CENTER_Y: sph_cy = $signed(val);
      REG_CENTER_Z: sph_cz = $signed(val);
      REG_RADIUS:   sph_r = {33'd0, val[30:0]};
      default: ;
    endcase
  endtask

  task automatic set_sphere(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] cz, input logic [31:0] r);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, r);
  endtask

  task automatic drain_all();
    while (ray_queue.size() != 0 || start || hit_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(input int span);
    logic [31:0] v;
    v = $urandom_range(2 * span, 0) - span;
    return v <<< 16 | $urandom_range(16'hffff, 0);
  endfunction

  // aimed ray: origin at a random offset from the center, direction roughly toward center
  task automatic add_aimed(input int span);
    ray_t ry;
    logic signed [31:0] cx, cy, cz;
    cx = sph_cx; cy = sph_cy; cz = sph_cz;
    ry.origin_x = cx + rnd_coord(span);
    ry.origin_y = cy + rnd_coord(span);
    ry.origin_z = cz + rnd_coord(span);
    ry.dir_x = (cx - ry.origin_x) / 4 + rnd_coord(1);
    ry.dir_y = (cy - ry.origin_y) / 4 + rnd_coord(1);
    ry.dir_z = (cz - ry.origin_z) / 4 + rnd_coord(1);
    case ($urandom_range(3, 0))
      0: begin ry.t_min = 0; ry.t_max = 32'sh7fff_ffff; end
      1: begin ry.t_min = -32'sd1000000; ry.t_max = rnd_coord(20); end
      2: begin ry.t_min = rnd_coord(4); ry.t_max = rnd_coord(40); end
      default: begin ry.t_min = $urandom; ry.t_max = $urandom; end
    endcase
    ray_queue.push_back(ry);
  endtask

  task automatic add_noise();
    ray_t ry;
    ry = {$urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom};
    ray_queue.push_back(ry);
  endtask

  task automatic add_ray(input logic [31:0] ox, input logic [31:0] oy,
                         input logic [31:0] oz, input logic [31:0] dx,
                         input logic [31:0] dy, input logic [31:0] dz,
                         input logic [31:0] tlo, input logic [31:0] thi);
    ray_t ry;
    ry = {ox, oy, oz, dx, dy, dz, tlo, thi};
    ray_queue.push_back(ry);
  endtask

  initial begin
    logic [31:0] mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    rst_n = 1'b0;
    start = 1'b0;
    in_ray = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_off = 1'b0;
    error_count = 0;
    sph_cx = 0; sph_cy = 0; sph_cz = 0; sph_r = 65536;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset sphere: unit sphere at origin
    add_ray(32'hfffb_0000, 0, 0, 32'h0001_0000, 0, 0, 0, mx);       // front hit
    add_ray(0, 0, 0, 32'h0001_0000, 0, 0, 0, mx);                    // inside, far root
    add_ray(32'hfffb_0000, 32'h0002_0000, 0, 32'h0001_0000, 0, 0, 0, mx); // miss
    add_ray(32'hfffb_0000, 0, 0, 32'h0000_0001, 0, 0, 0, mx);       // a floors to 0
    add_ray(32'hfffb_0000, 0, 0, 32'h0001_0000, 0, 0, mx, 0);       // reversed
    add_ray(32'hfffb_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0004_0000, 32'h0004_0000);
    add_ray(32'h0005_0000, 0, 0, 32'h0001_0000, 0, 0, mn, mx);      // behind
    add_ray(32'hfffb_0000, 32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0, mx); // tangent
    add_ray(mx, mx, mx, mn, mn, mn, mn, mx);
    add_ray(mn, mn, mn, mx, mx, mx, mn, mx);
    add_ray(mx, mn, mx, mx, mn, mx, mn, mx);
    add_ray(0, 0, 0, mx, 0, 0, mn, mx);
    add_ray(0, 0, 0, 32'h0000_0100, 0, 0, mn, mx);                  // small direction, a = 1 LSB
    add_ray(32'hffff_ffff, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, mn, mx);
    drain_all();

    set_sphere(mx, mn, 32'h0003_8000, mx);
    add_ray(0, 0, 0, 32'h0001_0000, 0, 0, mn, mx);
    add_ray(mx, mn, 0, 0, 0, 32'h0001_0000, mn, mx);
    repeat (20) add_aimed(30000);
    drain_all();

    set_sphere(0, 0, 0, 0);                                          // zero radius
    add_ray(32'hfffb_0000, 0, 0, 32'h0001_0000, 0, 0, mn, mx);
    repeat (10) add_noise();
    drain_all();

    set_sphere(mn, mx, mn, 1);
    repeat (20) add_aimed(4);
    drain_all();

    write_reg(3'd7, $urandom);                                       // unmapped index

    for (int phase = 0; phase < 6; phase++) begin
      set_sphere(rnd_coord(100), rnd_coord(100), rnd_coord(100),
                 {1'b0, 15'($urandom_range(20, 0)), 16'($urandom_range(16'hffff, 0))});
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(9, 0) < 8) add_aimed($urandom_range(3, 0) == 0 ? 1000 : 40);
        else add_noise();
        if (phase == 2 && k == 100) begin
          while (ray_queue.size() != 0) @(posedge clk);
          hold_off = 1'b1;
          while (start || hit_queue.size() != 0) @(posedge clk);
          hold_off = 1'b0;
        end
      end
      drain_all();
    end

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/rsi_pkg.sv
sv/rsi_quad.sv
sv/rsi_sqrt.sv
sv/rsi_div.sv
sv/ray_sphere_intersect.sv
tb/tb_ray_sphere_intersect.sv
